// ===== rtl/sus_pkg.sv =====
// ----------------------------------------------------------------------------
// sus_pkg
// Shared types and command codes for the sorted unique set.
// ----------------------------------------------------------------------------
package sus_pkg;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_READ   = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_CHECK,
        ST_SHIFT,
        ST_READ,
        ST_OUT
    } state_t;

endpackage

// ===== rtl/sorted_unique_set.sv =====
// ----------------------------------------------------------------------------
// sorted_unique_set
// Sorted table of distinct 32-bit values with insert, lookup, read, clear.
// ----------------------------------------------------------------------------
// One request at a time. The table lives in one memory with one read and one
// write port and a registered read. A lookup, or an insert of a key already
// present, makes at most ceil(log2(count+1)) binary-search probes and runs,
// with no stall, through the accept step, a read and then a compare for each
// probe, a read of the landing entry, a check step and the output step.
// Insert of a new key then moves each entry above the landing point up one
// place (read, then write, walking down from the top) and then writes the
// key. Read accepts, reads the entry and outputs it; clear accepts and goes
// straight to output. The result sits in an output register; the next
// request is taken after it is delivered.
module sorted_unique_set #(
    parameter int CAPACITY = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic [31:0] s_key_value,
    input  logic [7:0]  s_read_index,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_found,
    output logic [8:0]  m_position,
    output logic [8:0]  m_entry_total,
    output logic [31:0] m_read_value,
    output logic        m_full_flag
);
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic [31:0] mem [CAPACITY];
    logic [31:0] rdata;
    logic        mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [31:0] mem_wdata;

    always_ff @(posedge aclk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        rdata <= mem[mem_raddr];
    end

    sus_pkg::state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] lo_reg, lo_next, hi_reg, hi_next, idx_reg, idx_next;
    logic [1:0]    cmd_reg, cmd_next;
    logic [31:0]   key_reg, key_next;
    logic [7:0]    ridx_reg, ridx_next;
    logic          found_reg, found_next, full_reg, full_next;
    logic [31:0]   rval_reg, rval_next;
    logic [CW-1:0] mid;
    // probe sequencing: issue read at mid, evaluate next cycle
    logic          probe_reg, probe_next;
    logic [CW-1:0] pmid_reg, pmid_next;

    assign mid = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign s_ready = (state_reg == sus_pkg::ST_IDLE);
    assign m_valid = (state_reg == sus_pkg::ST_OUT);
    assign m_found = found_reg;
    assign m_position = 9'(lo_reg);
    assign m_entry_total = 9'(count_reg);
    assign m_read_value = rval_reg;
    assign m_full_flag = full_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sus_pkg::ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
        lo_reg <= lo_next; hi_reg <= hi_next; idx_reg <= idx_next;
        cmd_reg <= cmd_next; key_reg <= key_next; ridx_reg <= ridx_next;
        found_reg <= found_next; full_reg <= full_next; rval_reg <= rval_next;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            sus_pkg::ST_IDLE: if (s_valid) begin
                case (sus_pkg::cmd_t'(s_cmd))
                    sus_pkg::CMD_CLEAR: state_next = sus_pkg::ST_OUT;
                    sus_pkg::CMD_READ:  state_next = sus_pkg::ST_READ;
                    default:            state_next = sus_pkg::ST_SEARCH;
                endcase
            end
            sus_pkg::ST_SEARCH: if (lo_reg >= hi_reg) state_next = sus_pkg::ST_CHECK;
            sus_pkg::ST_CHECK: begin
                if (cmd_reg == sus_pkg::CMD_INSERT && !found_next && !full_next)
                    state_next = sus_pkg::ST_SHIFT;
                else
                    state_next = sus_pkg::ST_OUT;
            end
            sus_pkg::ST_SHIFT: if (idx_reg == lo_reg && hi_reg[0])
                state_next = sus_pkg::ST_OUT;
            sus_pkg::ST_READ: state_next = sus_pkg::ST_OUT;
            sus_pkg::ST_OUT: if (m_ready) state_next = sus_pkg::ST_IDLE;
            default: state_next = sus_pkg::ST_IDLE;
        endcase
    end

    // datapath and memory control
    // SHIFT reuses hi_reg[0] as read/write phase.
    always_comb begin
        count_next = count_reg;
        lo_next = lo_reg; hi_next = hi_reg; idx_next = idx_reg;
        cmd_next = cmd_reg; key_next = key_reg; ridx_next = ridx_reg;
        found_next = found_reg; full_next = full_reg; rval_next = rval_reg;
        mem_we = 1'b0; mem_waddr = AW'(idx_reg); mem_wdata = key_reg;
        mem_raddr = AW'(mid);
        case (state_reg)
            sus_pkg::ST_IDLE: begin
                cmd_next = s_cmd; key_next = s_key_value; ridx_next = s_read_index;
                lo_next = '0; hi_next = count_reg;
                found_next = 1'b0; full_next = 1'b0; rval_next = '0;
                mem_raddr = AW'(s_read_index);
                if (s_valid && sus_pkg::cmd_t'(s_cmd) == sus_pkg::CMD_CLEAR)
                    count_next = '0;
            end
            sus_pkg::ST_CHECK: begin
                found_next = (lo_reg < count_reg) && (rdata == key_reg);
                full_next = !found_next && (count_reg >= CW'(CAPACITY))
                            && (cmd_reg == sus_pkg::CMD_INSERT);
                idx_next = count_reg;
                hi_next = '0;
            end
            sus_pkg::ST_SHIFT: begin
                if (!hi_reg[0]) begin
                    if (idx_reg == lo_reg) begin
                        hi_next = CW'(1);
                    end else begin
                        mem_raddr = AW'(idx_reg - 1'b1);
                        hi_next = CW'(1);
                    end
                end else begin
                    mem_we = 1'b1;
                    mem_waddr = AW'(idx_reg);
                    if (idx_reg == lo_reg) begin
                        mem_wdata = key_reg;
                        count_next = count_reg + 1'b1;
                    end else begin
                        mem_wdata = rdata;
                        idx_next = idx_reg - 1'b1;
                        hi_next = '0;
                    end
                end
            end
            sus_pkg::ST_READ: begin
                if (32'(ridx_reg) < 32'(count_reg)) rval_next = rdata;
            end
            default: ;
        endcase
        if (state_reg == sus_pkg::ST_SEARCH) begin
            if (probe_reg) begin
                if (rdata < key_reg) lo_next = pmid_reg + 1'b1;
                else hi_next = pmid_reg;
                mem_raddr = AW'(lo_reg);
            end else if (lo_reg < hi_reg) begin
                mem_raddr = AW'(mid);
            end else begin
                mem_raddr = AW'(lo_reg);
            end
        end
    end

    always_comb begin
        probe_next = 1'b0;
        pmid_next = pmid_reg;
        if (state_reg == sus_pkg::ST_SEARCH && !probe_reg && lo_reg < hi_reg) begin
            probe_next = 1'b1;
            pmid_next = mid;
        end
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) probe_reg <= 1'b0;
        else probe_reg <= probe_next;
        pmid_reg <= pmid_next;
    end

endmodule

// ===== rtl/sus_checker.sv =====
// ----------------------------------------------------------------------------
// sus_checker
// Port-level checks for the sorted unique set.
// ----------------------------------------------------------------------------
module sus_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_found,
    input logic [8:0]  m_position,
    input logic [8:0]  m_entry_total,
    input logic [31:0] m_read_value,
    input logic        m_full_flag
);
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_position)
        && $stable(m_entry_total) && $stable(m_read_value))
        else $error("result changed while stalled");
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("request taken while result pending");
    a_found_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_found && m_full_flag))
        else $error("found and full together");
    a_total_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_found |-> m_position < m_entry_total)
        else $error("found position beyond total");
endmodule

bind sorted_unique_set sus_checker u_sus_checker (.*);
